// File: design/cb_pkg.sv
// Shared types and constants for the comment blanker.
package cb_pkg;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Scanner mode.
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_LINE   = 2'd1,
        MODE_BLOCK  = 2'd2
    } t_mode;

    // One queue entry: the one or two result bytes that one input beat released.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
    } t_entry;

endpackage

// File: design/cb_front.sv
// Front end: accepts input beats, tracks comment state and classifies each byte.
module cb_front
    import cb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_entry     o_entry
);

    t_mode      r_mode, n_mode;
    logic       r_held, n_held;
    logic [1:0] cnt;
    logic [7:0] b0, b1, x;
    logic       closed;
    logic       accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // Classify the incoming byte against the current mode.
    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        cnt    = 2'd0;
        b0     = i_text_byte;
        b1     = i_text_byte;
        closed = 1'b0;
        x      = i_text_byte;
        case (r_mode)
            MODE_LINE: begin
                cnt = 2'd1;
                if (i_text_byte == CH_NL) begin
                    b0     = CH_NL;
                    n_mode = MODE_NORMAL;
                end else begin
                    b0 = CH_SP;
                end
            end
            MODE_BLOCK: begin
                if (r_held) begin
                    n_held = 1'b0;
                    if (i_text_byte == CH_SLASH) begin
                        cnt    = 2'd2;
                        b0     = CH_SP;
                        b1     = CH_SP;
                        n_mode = MODE_NORMAL;
                        closed = 1'b1;
                    end else begin
                        cnt = 2'd1;
                        b0  = CH_SP;
                    end
                end
                if (!closed) begin
                    if (i_text_byte == CH_STAR && !i_end_of_text) begin
                        n_held = 1'b1;
                    end else begin
                        // The final byte of an unterminated comment passes unchanged.
                        if (i_end_of_text) begin
                            x = i_text_byte;
                        end else if (i_text_byte == CH_NL) begin
                            x = CH_NL;
                        end else begin
                            x = CH_SP;
                        end
                        if (cnt == 2'd1) begin
                            b1  = x;
                            cnt = 2'd2;
                        end else begin
                            b0  = x;
                            cnt = 2'd1;
                        end
                    end
                end
            end
            default: begin
                if (r_held) begin
                    n_held = 1'b0;
                    cnt    = 2'd2;
                    if (i_text_byte == CH_SLASH) begin
                        b0     = CH_SP;
                        b1     = CH_SP;
                        n_mode = MODE_LINE;
                    end else if (i_text_byte == CH_STAR) begin
                        b0     = CH_SP;
                        b1     = CH_SP;
                        n_mode = MODE_BLOCK;
                    end else begin
                        b0 = CH_SLASH;
                        b1 = i_text_byte;
                    end
                end else if (i_text_byte == CH_SLASH && !i_end_of_text) begin
                    n_held = 1'b1;
                end else begin
                    cnt = 2'd1;
                    b0  = i_text_byte;
                end
            end
        endcase
        // The end of a text returns the scanner to its reset state.
        if (i_end_of_text) begin
            n_mode = MODE_NORMAL;
            n_held = 1'b0;
        end
    end

    assign o_push       = accept && (cnt != 2'd0);
    assign o_entry.two  = (cnt == 2'd2);
    assign o_entry.byte0 = b0;
    assign o_entry.byte1 = b1;
    assign o_entry.last = i_end_of_text;

    // Scanner state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_held <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

endmodule

// File: design/cb_queue.sv
// Short queue of classified entries between front and back.
module cb_queue
    import cb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/cb_back.sv
// Back end: unpacks queue entries into single output beats through an output register.
module cb_back
    import cb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_end
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_second;
    logic       load;
    logic       first_of_two;

    // The output register takes a new beat when it is empty or being drained.
    assign load         = !i_empty && (!r_valid || !i_stall);
    assign first_of_two = i_head.two && !r_second;
    assign o_pop        = load && !first_of_two;

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_second <= first_of_two;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload of the output beat.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= r_second ? i_head.byte1 : (i_head.two ? i_head.byte0 : i_head.byte0);
            r_end  <= first_of_two ? 1'b0 : i_head.last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_out_end  = r_end;

endmodule

// File: design/comment_blanker.sv
// Top level of the streaming C/C++ comment blanker.
//
// Input channel: i_valid / o_stall carry one text byte per beat, with
// i_end_of_text marking the final byte of a text. Output channel:
// o_valid / i_stall carry one byte per beat; o_out_end marks the last
// output byte of a text. Comments come out as spaces, newlines are kept.
// A front end classifies each input byte and may release zero, one or two
// output bytes; a small queue of QUEUE_DEPTH entries separates it from the
// back end, which sends one byte per cycle, unless the receiver stalls,
// through an output register. Throughput: one input beat per cycle while
// the queue has room. A beat that releases two bytes occupies the back end
// until both leave, which the queue absorbs since held bytes release none.
// When idle, an input beat passes through the queue and the output register.
// Reset (synchronous, active low) clears the scanner state, the queue and
// the output register. When the receiver stalls, the output beat holds,
// the queue fills, and o_stall rises once the queue is full.
module comment_blanker
    import cb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_end
);

    logic   push, pop, full, empty;
    t_entry entry_in, head;

    // Classification and scanner state.
    cb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_full        (full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_entry       (entry_in)
    );

    // Decoupling queue.
    cb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Output serialization.
    cb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_end  (o_out_end)
    );

endmodule
